/* sv/vfd_pkg.sv */
`default_nettype none

package vfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int TDATA_W = BYTE_W + 4 * WORD_W;   // 136 bits, whole bytes
    localparam int TUSER_W = 2;

    // "MCVIDEO0", first received byte in the top bits
    localparam logic [63:0] MAGIC_WORD = 64'h4D43_5649_4445_4F30;

    // index of the last header byte (16 header bytes)
    localparam logic [3:0] HDR_LAST = 4'd15;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              keep;
        logic              compressed;
        logic [WORD_W-1:0] row_index;
        logic [WORD_W-1:0] column_index;
        logic [WORD_W-1:0] width_out;
        logic [WORD_W-1:0] height_out;
        logic              end_of_frame;
    } result_t;

endpackage

`default_nettype wire

/* sv/vfd_in_stage.sv */
`default_nettype none

module vfd_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire vfd_pkg::item_t s_item,
    output logic                item_valid,
    output vfd_pkg::item_t      item,
    input  wire logic           take
);
    import vfd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free slot, or the held word leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* sv/vfd_parser.sv */
`default_nettype none

module vfd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire vfd_pkg::item_t   item,
    input  wire logic             out_ready,
    output logic                  take,
    output logic                  res_valid,
    output vfd_pkg::result_t      result
);
    import vfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t            phase_reg,      phase_next;
    logic [63:0]       window_reg,     window_next;
    logic [3:0]        hdr_cnt_reg,    hdr_cnt_next;
    logic [WORD_W-1:0] width_reg,      width_next;
    logic [WORD_W-1:0] height_reg,     height_next;
    logic [WORD_W-1:0] stride_reg,     stride_next;
    logic [WORD_W-1:0] pay_len_reg,    pay_len_next;
    logic [WORD_W-1:0] pay_cnt_reg,    pay_cnt_next;
    logic [WORD_W-1:0] row_cnt_reg,    row_cnt_next;
    logic [WORD_W-1:0] col_cnt_reg,    col_cnt_next;

    logic [63:0]       window_shift;
    logic [WORD_W-1:0] pay_len_final;
    logic [WORD_W-1:0] pay_cnt_inc;
    logic [WORD_W-1:0] col_cnt_inc;
    logic [WORD_W+1:0] width_x4;
    logic              stride_zero;
    logic              raw_keep;
    logic [4:0]        lane_lsb;

    assign take = item_valid && out_ready;

    assign window_shift  = {window_reg[55:0], item.in_byte};
    assign pay_len_final = {item.in_byte, pay_len_reg[23:0]};
    assign pay_cnt_inc   = pay_cnt_reg + 32'd1;
    assign col_cnt_inc   = col_cnt_reg + 32'd1;
    assign width_x4      = {width_reg, 2'b00};
    assign stride_zero   = (stride_reg == '0);
    assign lane_lsb      = {hdr_cnt_reg[1:0], 3'b000};

    // col < min(stride, width*4) split into two parallel compares
    assign raw_keep = (row_cnt_reg < height_reg) &&
                      (col_cnt_reg < stride_reg) &&
                      ({2'b00, col_cnt_reg} < width_x4);

    always_comb
    begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        hdr_cnt_next = hdr_cnt_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        stride_next  = stride_reg;
        pay_len_next = pay_len_reg;
        pay_cnt_next = pay_cnt_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;

        res_valid           = 1'b0;
        result.data_byte    = item.in_byte;
        result.keep         = 1'b0;
        result.compressed   = stride_zero;
        result.row_index    = '0;
        result.column_index = '0;
        result.width_out    = width_reg;
        result.height_out   = height_reg;
        result.end_of_frame = 1'b0;

        if (take)
        begin
            if (item.op == OP_RESTART)
            begin
                phase_next   = PH_HUNT;
                window_next  = '0;
                hdr_cnt_next = '0;
                width_next   = '0;
                height_next  = '0;
                stride_next  = '0;
                pay_len_next = '0;
                pay_cnt_next = '0;
                row_cnt_next = '0;
                col_cnt_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        // little-endian header words, one byte lane per byte
                        case (hdr_cnt_reg[3:2])
                            2'd0:    width_next[lane_lsb +: 8]   = item.in_byte;
                            2'd1:    height_next[lane_lsb +: 8]  = item.in_byte;
                            2'd2:    stride_next[lane_lsb +: 8]  = item.in_byte;
                            default: pay_len_next[lane_lsb +: 8] = item.in_byte;
                        endcase
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                        if (hdr_cnt_reg == HDR_LAST)
                        begin
                            pay_cnt_next = '0;
                            row_cnt_next = '0;
                            col_cnt_next = '0;
                            hdr_cnt_next = '0;
                            if (pay_len_final == '0)
                            begin
                                // empty payload: lone end-of-frame word
                                res_valid           = 1'b1;
                                result.data_byte    = '0;
                                result.end_of_frame = 1'b1;
                                phase_next          = PH_HUNT;
                                window_next         = '0;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end

                    PH_PAYLOAD:
                    begin
                        res_valid = 1'b1;
                        if (stride_zero)
                        begin
                            result.keep         = 1'b1;
                            result.column_index = pay_cnt_reg;
                        end
                        else
                        begin
                            result.keep         = raw_keep;
                            result.row_index    = row_cnt_reg;
                            result.column_index = col_cnt_reg;
                            if (col_cnt_inc >= stride_reg)
                            begin
                                col_cnt_next = '0;
                                row_cnt_next = row_cnt_reg + 32'd1;
                            end
                            else
                            begin
                                col_cnt_next = col_cnt_inc;
                            end
                        end
                        pay_cnt_next = pay_cnt_inc;
                        if (pay_cnt_inc >= pay_len_reg)
                        begin
                            result.end_of_frame = 1'b1;
                            phase_next          = PH_HUNT;
                            window_next         = '0;
                            hdr_cnt_next        = '0;
                        end
                    end

                    default:
                    begin
                        // hunting; the unused phase code hunts as well
                        window_next = window_shift;
                        phase_next  = PH_HUNT;
                        if (window_shift == MAGIC_WORD)
                        begin
                            phase_next   = PH_HEADER;
                            hdr_cnt_next = '0;
                            width_next   = '0;
                            height_next  = '0;
                            stride_next  = '0;
                            pay_len_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            window_reg  <= '0;
            hdr_cnt_reg <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            stride_reg  <= '0;
            pay_len_reg <= '0;
            pay_cnt_reg <= '0;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            hdr_cnt_reg <= hdr_cnt_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            stride_reg  <= stride_next;
            pay_len_reg <= pay_len_next;
            pay_cnt_reg <= pay_cnt_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PH_PAYLOAD) ||
                      (phase_reg == PH_HEADER && hdr_cnt_reg == HDR_LAST))
        else $error("result word outside payload or header end");

    a_comp_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result.compressed |-> result.row_index == '0)
        else $error("compressed word with nonzero row");

    a_eof_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result.end_of_frame |=> phase_reg == PH_HUNT && window_reg == '0)
        else $error("frame end did not restart hunting");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD && stride_reg != '0 |-> col_cnt_reg < stride_reg)
        else $error("column counter beyond stride");
`endif

endmodule

`default_nettype wire

/* sv/vfd_out_stage.sv */
`default_nettype none

module vfd_out_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      res_valid,
    input  wire vfd_pkg::result_t          result,
    output logic                           out_ready,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [vfd_pkg::TDATA_W-1:0]    m_data,
    output logic [vfd_pkg::TUSER_W-1:0]    m_user,
    output logic                           m_last
);
    import vfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {res_reg.height_out, res_reg.width_out, res_reg.column_index,
                      res_reg.row_index, res_reg.data_byte};
    assign m_user  = {res_reg.compressed, res_reg.keep};
    assign m_last  = res_reg.end_of_frame;

endmodule

`default_nettype wire

/* sv/video_frame_deframer.sv */
`default_nettype none

// Channel   Dir  tdata (low bit up)                        tuser               tlast
// s_axis    in   [7:0] in_byte                             [0] op (1=restart)  -
// m_axis    out  [7:0] data_byte, [39:8] row_index,        [0] keep,           end_of_frame
//                [71:40] column_index, [103:72] width_out, [1] compressed
//                [135:104] height_out
//
// One input word per clock, sustained while m_axis_tready is high; an accepted word passes the input
// register, then parse logic into the result register, before m_axis_tvalid rises.
// Header and hunt words produce nothing; each payload word produces one output word, and a
// header with zero payload length produces one end-of-frame word.
// rst_n clears the parser to the hunting state with an empty sync window; a restart word
// (tuser = 1) does the same in-band.
// Backpressure on m_axis stalls the parser and then the input register; s_axis_tready
// stays high while the result register drains in the same cycle.

module video_frame_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [vfd_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    input  wire logic                          s_axis_tuser,   // [0] op

    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [vfd_pkg::TDATA_W-1:0]        m_axis_tdata,   // data_byte, row, column,
                                                               // width, height
    output logic [vfd_pkg::TUSER_W-1:0]        m_axis_tuser,   // [0] keep, [1] compressed
    output logic                               m_axis_tlast    // end_of_frame
);
    import vfd_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    out_ready;
    logic    res_valid;
    result_t result;

    assign s_item.op      = op_t'(s_axis_tuser);
    assign s_item.in_byte = s_axis_tdata;

    vfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    // sync hunt, header capture, row/column counters
    vfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .result     (result)
    );

    vfd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .result     (result),
        .out_ready  (out_ready),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire
